// ----- hdl/epid_pkg.sv -----
// Package for the expiring packet id store: payload structs and request codes.
// No dependencies.
package epid_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_DEQUEUE = 3'd1,
    REQ_FIND    = 3'd2,
    REQ_DROP    = 3'd3,
    REQ_PURGE   = 3'd4,
    REQ_LIST    = 3'd5
  } req_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] packet_id;
    logic [47:0] expire_time;
    logic [31:0] packet_uid;
    logic [47:0] now_time;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] out_id;
    logic [47:0] out_expire;
    logic [31:0] out_uid;
    logic [4:0]  entry_count;
    logic        last;
  } rsp_t;

endpackage

// ----- hdl/expiring_packet_id_store_unit.sv -----
// Top level of the expiring packet id store: slot table, scan sequencer and output register.
// Depends on epid_pkg.
//
// Usage: one request transaction enters on req_valid_i/req_ready_o. The block then
// scans its DEPTH slots one per cycle with a single shared compare unit. It sends
// one or more response transactions on rsp_valid_o/rsp_ready_i. Insert, dequeue,
// find, drop, purge and the unused request codes give one response. List gives one
// response per record in ascending id order, with the final one marked last, or one
// empty response when the table is empty.
// Steps: a single-pass request scans all DEPTH slots, then takes an action step and
// an emit step, in which its response is loaded into the output register. The next
// request can be taken once the sequencer is back in idle.
// Insert with eviction and list over the limit add a further scan pass and action step.
// Each listed record takes its own scan, action and emit steps; unused codes go to emit.
// When the receiver stalls, the held response waits in the output register and the
// sequencer waits in its emit step. A new request is taken only when idle.
// The limit register is written on cfg_valid_i/cfg_ready_o and resets to 16.
// Reset clears all slot valid bits and the record count. Slot contents are not cleared.
module expiring_packet_id_store_unit
  import epid_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int TIME_BITS = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output rsp_t       rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ACT  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  // Scan kinds: what the compare unit looks for in a pass.
  typedef enum logic [2:0] {
    K_MATCH = 3'd0, K_MINID = 3'd1, K_EARLY = 3'd2, K_DROP = 3'd3,
    K_PURGE = 3'd4, K_NEXT = 3'd5
  } kind_e;

  state_e state_q;
  kind_e  kind_q;
  req_t   req_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] cnt_q;
  logic [4:0]    lim_q;
  logic [DEPTH-1:0] vld_q;
  logic [31:0]          sid_q [DEPTH];
  logic [TIME_BITS-1:0] sex_q [DEPTH];
  logic [31:0]          suid_q [DEPTH];
  logic          bf_q, fr_q;   // best found, free slot found
  logic [IW-1:0] bi_q, fi_q;
  logic [31:0]   bid_q, buid_q;
  logic [TIME_BITS-1:0] bex_q;
  logic          hp_q;
  logic [31:0]   prev_q;
  logic [CW-1:0] nout_q;
  logic          ins_full_q, ins_self_q;
  logic          rv_q;
  rsp_t          rsp_q, rsp_d;

  logic [TIME_BITS-1:0] rex, rnow;
  assign rex  = TIME_BITS'(req_q.expire_time);
  assign rnow = TIME_BITS'(req_q.now_time);

  // Effective limit: the register clamped to the table depth.
  logic [CW-1:0] elim;
  always_comb begin
    if (32'(lim_q) > 32'(DEPTH)) elim = CW'(DEPTH);
    else                         elim = CW'(lim_q);
  end

  // Shared compare unit over the current slot.
  logic cv, better;
  logic [31:0] cid, cuid;
  logic [TIME_BITS-1:0] cex;
  always_comb begin
    cv     = vld_q[idx_q];
    cid    = sid_q[idx_q];
    cex    = sex_q[idx_q];
    cuid   = suid_q[idx_q];
    better = 1'b0;
    unique case (kind_q)
      K_MATCH: better = cv && !bf_q && (cid == req_q.packet_id);
      K_MINID: better = cv && (!bf_q || cid < bid_q);
      K_EARLY: better = cv && (!bf_q || cex < bex_q || (cex == bex_q && cid < bid_q));
      K_DROP:  better = cv && (cuid == req_q.packet_uid);
      K_PURGE: better = cv && (cex < rnow);
      K_NEXT:  better = cv && (!hp_q || cid > prev_q) && (!bf_q || cid < bid_q);
      default: better = 1'b0;
    endcase
  end

  // On a full table the incoming record loses the eviction when it expires first,
  // or expires together with the earliest record and has the smaller id.
  logic self_loses;
  assign self_loses = !bf_q || (rex < bex_q) ||
                      (rex == bex_q && req_q.packet_id < bid_q);

  logic last_slot;
  assign last_slot   = (idx_q == IW'(DEPTH - 1));
  assign req_ready_o = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  // Single write port of the slot contents, used in the action step of an insert.
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = bi_q;
    if (state_q == S_ACT && req_q.req_type == REQ_INSERT) begin
      if (kind_q == K_MATCH && bf_q) begin
        wr_en = 1'b1;
      end else if (kind_q == K_MATCH && fr_q) begin
        wr_en  = 1'b1;
        wr_idx = fi_q;
      end else if (kind_q == K_EARLY && ins_full_q && !self_loses) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sid_q[wr_idx]  <= req_q.packet_id;
      sex_q[wr_idx]  <= rex;
      suid_q[wr_idx] <= req_q.packet_uid;
    end
  end

  // Response selection for the emit step.
  logic e_hit, e_last, e_done;
  logic [31:0] e_id, e_uid;
  logic [TIME_BITS-1:0] e_ex;
  always_comb begin
    e_hit  = 1'b0;
    e_id   = bid_q;
    e_ex   = bex_q;
    e_uid  = buid_q;
    e_last = 1'b1;
    e_done = 1'b1;
    unique case (req_q.req_type)
      REQ_INSERT: begin
        e_hit = (kind_q == K_EARLY) && (ins_self_q || bf_q);
        if (ins_self_q) begin
          e_id  = req_q.packet_id;
          e_ex  = rex;
          e_uid = req_q.packet_uid;
        end
      end
      REQ_DEQUEUE, REQ_FIND: e_hit = bf_q;
      REQ_LIST: begin
        e_hit  = bf_q;
        e_last = !bf_q || ((nout_q + CW'(1)) == cnt_q);
        e_done = e_last;
      end
      default: e_hit = 1'b0;
    endcase
  end

  always_comb begin
    rsp_d.hit         = e_hit;
    rsp_d.out_id      = e_hit ? e_id : '0;
    rsp_d.out_expire  = e_hit ? 48'(e_ex) : '0;
    rsp_d.out_uid     = e_hit ? e_uid : '0;
    rsp_d.entry_count = 5'(cnt_q);
    rsp_d.last        = e_last;
  end

  logic load_rsp;
  assign load_rsp = (state_q == S_EMIT) && (!rv_q || rsp_ready_i);

  // Sequencer, valid bits, record count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      kind_q     <= K_MATCH;
      req_q      <= '0;
      idx_q      <= '0;
      cnt_q      <= '0;
      lim_q      <= 5'd16;
      vld_q      <= '0;
      bf_q       <= 1'b0;
      fr_q       <= 1'b0;
      bi_q       <= '0;
      fi_q       <= '0;
      bid_q      <= '0;
      buid_q     <= '0;
      bex_q      <= '0;
      hp_q       <= 1'b0;
      prev_q     <= '0;
      nout_q     <= '0;
      ins_full_q <= 1'b0;
      ins_self_q <= 1'b0;
      rv_q       <= 1'b0;
      rsp_q      <= '0;
    end else begin
      if (cfg_valid_i) lim_q <= cfg_data_i;
      rv_q <= load_rsp || (rv_q && !rsp_ready_i);
      if (load_rsp) rsp_q <= rsp_d;
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q      <= req_i;
            idx_q      <= '0;
            bf_q       <= 1'b0;
            fr_q       <= 1'b0;
            hp_q       <= 1'b0;
            nout_q     <= '0;
            ins_full_q <= 1'b0;
            ins_self_q <= 1'b0;
            unique case (req_i.req_type)
              REQ_INSERT, REQ_FIND: begin
                kind_q  <= K_MATCH;
                state_q <= S_SCAN;
              end
              REQ_DEQUEUE: begin
                kind_q  <= K_MINID;
                state_q <= S_SCAN;
              end
              REQ_DROP: begin
                kind_q  <= K_DROP;
                state_q <= S_SCAN;
              end
              REQ_PURGE: begin
                kind_q  <= K_PURGE;
                state_q <= S_SCAN;
              end
              REQ_LIST: begin
                // Over the limit, one earliest-expiry record goes before listing.
                kind_q  <= (cnt_q > elim) ? K_EARLY : K_NEXT;
                state_q <= S_SCAN;
              end
              default: state_q <= S_EMIT;
            endcase
          end
        end
        S_SCAN: begin
          if (better) begin
            if (kind_q == K_DROP || kind_q == K_PURGE) begin
              vld_q[idx_q] <= 1'b0;
              cnt_q        <= cnt_q - CW'(1);
            end else begin
              bf_q   <= 1'b1;
              bi_q   <= idx_q;
              bid_q  <= cid;
              bex_q  <= cex;
              buid_q <= cuid;
            end
          end
          if (kind_q == K_MATCH && !cv && !fr_q) begin
            fr_q <= 1'b1;
            fi_q <= idx_q;
          end
          if (last_slot) begin
            idx_q   <= '0;
            state_q <= S_ACT;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_ACT: begin
          unique case (kind_q)
            K_MATCH: begin
              if (req_q.req_type == REQ_INSERT && bf_q) begin
                // Update in place; the count is unchanged but may still exceed the limit.
                if (cnt_q > elim) begin
                  kind_q  <= K_EARLY;
                  bf_q    <= 1'b0;
                  state_q <= S_SCAN;
                end else begin
                  state_q <= S_EMIT;
                end
              end else if (req_q.req_type == REQ_INSERT && fr_q) begin
                vld_q[fi_q] <= 1'b1;
                cnt_q       <= cnt_q + CW'(1);
                if ((cnt_q + CW'(1)) > elim) begin
                  kind_q  <= K_EARLY;
                  state_q <= S_SCAN;
                end else begin
                  state_q <= S_EMIT;
                end
              end else if (req_q.req_type == REQ_INSERT) begin
                // Full table: the incoming record competes in the eviction pass.
                ins_full_q <= 1'b1;
                kind_q     <= K_EARLY;
                state_q    <= S_SCAN;
              end else begin
                state_q <= S_EMIT;
              end
            end
            K_MINID: begin
              if (bf_q) begin
                vld_q[bi_q] <= 1'b0;
                cnt_q       <= cnt_q - CW'(1);
              end
              state_q <= S_EMIT;
            end
            K_EARLY: begin
              if (req_q.req_type == REQ_LIST) begin
                if (bf_q) begin
                  vld_q[bi_q] <= 1'b0;
                  cnt_q       <= cnt_q - CW'(1);
                end
                kind_q  <= K_NEXT;
                bf_q    <= 1'b0;
                state_q <= S_SCAN;
              end else begin
                if (ins_full_q) begin
                  if (self_loses) ins_self_q <= 1'b1;
                end else if (bf_q) begin
                  vld_q[bi_q] <= 1'b0;
                  cnt_q       <= cnt_q - CW'(1);
                end
                state_q <= S_EMIT;
              end
            end
            default: state_q <= S_EMIT;
          endcase
        end
        S_EMIT: begin
          if (load_rsp) begin
            if (e_done) begin
              state_q <= S_IDLE;
            end else begin
              // Next listing pass: smallest id above the one just sent.
              hp_q    <= 1'b1;
              prev_q  <= bid_q;
              nout_q  <= nout_q + CW'(1);
              bf_q    <= 1'b0;
              idx_q   <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
